@@ src/nmcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest mean colour match: shared package
// Types, function codes and fixed widths used across the block.
// ----------------------------------------------------------------------------
package nmcm_pkg;

	localparam int COLOR_W = 8;
	localparam int DIST_W  = 10;
	localparam int TOL_W   = 8;
	localparam int LIMIT_W = DIST_W + TOL_W;
	localparam int RND_W   = 16;
	localparam int MATCH_W = 10;
	localparam int GOOD_W  = 11;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [TOL_W-1:0] TOL_RESET = 8'd16;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIN,
		ST_LIMIT,
		ST_COUNT,
		ST_RANK,
		ST_PICK,
		ST_DONE
	} state_t;

endpackage

@@ src/nmcm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest mean colour match: palette memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module nmcm_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  nmcm_pkg::color_t      wdata,
	input  logic                  re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output nmcm_pkg::color_t      rdata
);

	nmcm_pkg::color_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/nmcm_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest mean colour match: distance stage
// Registered L1 distance between a palette entry and the query colour.
// ----------------------------------------------------------------------------
module nmcm_dist (
	input  logic                          clk,
	input  nmcm_pkg::color_t              entry,
	input  nmcm_pkg::color_t              query,
	output logic [nmcm_pkg::DIST_W-1:0]   dist_s2
);

	logic [nmcm_pkg::COLOR_W-1:0] diff_b;
	logic [nmcm_pkg::COLOR_W-1:0] diff_g;
	logic [nmcm_pkg::COLOR_W-1:0] diff_r;

	assign diff_b = (entry.blue > query.blue) ? entry.blue - query.blue
		: query.blue - entry.blue;
	assign diff_g = (entry.green > query.green) ? entry.green - query.green
		: query.green - entry.green;
	assign diff_r = (entry.red > query.red) ? entry.red - query.red
		: query.red - entry.red;

	always_ff @(posedge clk) begin
		dist_s2 <= nmcm_pkg::DIST_W'(diff_b) + nmcm_pkg::DIST_W'(diff_g)
			+ nmcm_pkg::DIST_W'(diff_r);
	end

endmodule

@@ src/nearest_mean_color_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest mean colour match
// Palette of mean colours with append, clear and a tolerant nearest search.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// in        in_valid / in_ready       func, color_blue/green/red, random_value
// out       out_valid / out_ready     match_index, good_count, palette_empty
// config    tolerance_x16_we          tolerance_x16
//
// Append, clear and unused codes are accepted without leaving idle. A query
// runs a minimum pass, a limit step, a counting pass and a rank step, then a
// ranking pass that is left out when at most one entry is good; each pass reads
// one entry per cycle and drains its read and distance stages. An empty palette
// skips the passes. Reset clears the count, read pipeline and output valid and
// loads the default tolerance. A result that cannot yet be loaded holds the input.
// ----------------------------------------------------------------------------
module nearest_mean_color_match #(
	parameter int PALETTE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tolerance_x16_we,
	input  logic [nmcm_pkg::TOL_W-1:0]        tolerance_x16,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [nmcm_pkg::COLOR_W-1:0]      color_blue,
	input  logic [nmcm_pkg::COLOR_W-1:0]      color_green,
	input  logic [nmcm_pkg::COLOR_W-1:0]      color_red,
	input  logic [nmcm_pkg::RND_W-1:0]        random_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nmcm_pkg::MATCH_W-1:0]      match_index,
	output logic [nmcm_pkg::GOOD_W-1:0]       good_count,
	output logic                              palette_empty
);

	localparam int IDX_W  = $clog2(PALETTE_DEPTH);
	localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
	localparam int PROD_W = nmcm_pkg::RND_W + CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PALETTE_DEPTH);

	nmcm_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]            entry_count_q;
	logic [nmcm_pkg::TOL_W-1:0]  tolerance_q;
	nmcm_pkg::color_t            query_q;
	logic [nmcm_pkg::RND_W-1:0]  rnd_q;

	logic [CNT_W-1:0]            addr_q;
	logic                        rd_vld_s1;
	logic [IDX_W-1:0]            rd_idx_s1;
	logic                        vld_s2;
	logic [IDX_W-1:0]            idx_s2;
	logic [nmcm_pkg::DIST_W-1:0] dist_s2;

	logic [nmcm_pkg::DIST_W-1:0]  min_d_q;
	logic [IDX_W-1:0]             min_i_q;
	logic [nmcm_pkg::LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             rank_q;
	logic [CNT_W-1:0]             seen_q;
	logic                         found_q;
	logic [IDX_W-1:0]             pick_q;
	logic                         empty_q;

	logic                         out_valid_q;
	logic [nmcm_pkg::MATCH_W-1:0] match_index_q;
	logic [nmcm_pkg::GOOD_W-1:0]  good_count_q;
	logic                         palette_empty_q;

	logic             in_acc;
	logic             ram_we;
	nmcm_pkg::color_t ram_wdata;
	nmcm_pkg::color_t ram_rdata;
	logic             rd_en;
	logic             pass_done;
	logic             is_good;
	logic             out_load;
	logic [PROD_W-1:0] rank_prod;

	assign in_ready  = (state_q == nmcm_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign ram_we    = in_acc && (func == nmcm_pkg::FUNC_APPEND) && (entry_count_q < DEPTH_C);
	assign ram_wdata = '{red: color_red, green: color_green, blue: color_blue};
	assign is_good   = (nmcm_pkg::LIMIT_W'({dist_s2, 4'b0000}) < limit_q);
	assign out_load  = (state_q == nmcm_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign rank_prod = PROD_W'(rnd_q) * PROD_W'(count_q);

	nmcm_ram #(
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_count_q[IDX_W-1:0]),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	nmcm_dist u_dist (
		.clk     (clk),
		.entry   (ram_rdata),
		.query   (query_q),
		.dist_s2 (dist_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nmcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		pass_done = 1'b0;
		unique case (state_q)
			nmcm_pkg::ST_IDLE: begin
				if (in_acc && func == nmcm_pkg::FUNC_QUERY) begin
					state_d = (entry_count_q == '0) ? nmcm_pkg::ST_DONE : nmcm_pkg::ST_MIN;
				end
			end
			nmcm_pkg::ST_MIN, nmcm_pkg::ST_COUNT, nmcm_pkg::ST_PICK: begin
				rd_en     = (addr_q < entry_count_q);
				pass_done = (addr_q == entry_count_q) && !rd_vld_s1 && !vld_s2;
				if (pass_done) begin
					unique case (state_q)
						nmcm_pkg::ST_MIN:   state_d = nmcm_pkg::ST_LIMIT;
						nmcm_pkg::ST_COUNT: state_d = nmcm_pkg::ST_RANK;
						default:            state_d = nmcm_pkg::ST_DONE;
					endcase
				end
			end
			nmcm_pkg::ST_LIMIT: begin
				state_d = nmcm_pkg::ST_COUNT;
			end
			nmcm_pkg::ST_RANK: begin
				state_d = (count_q > CNT_W'(1)) ? nmcm_pkg::ST_PICK : nmcm_pkg::ST_DONE;
			end
			nmcm_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = nmcm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nmcm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			tolerance_q   <= nmcm_pkg::TOL_RESET;
			addr_q        <= '0;
			rd_vld_s1     <= 1'b0;
			vld_s2        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (tolerance_x16_we) begin
				tolerance_q <= tolerance_x16;
			end
			if (in_acc) begin
				if (ram_we) begin
					entry_count_q <= entry_count_q + CNT_W'(1);
				end else if (func == nmcm_pkg::FUNC_CLEAR) begin
					entry_count_q <= '0;
				end
			end
			if (rd_en) begin
				addr_q <= addr_q + CNT_W'(1);
			end else if (pass_done) begin
				addr_q <= '0;
			end
			rd_vld_s1 <= rd_en;
			vld_s2    <= rd_vld_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IDX_W-1:0];
		idx_s2    <= rd_idx_s1;
		if (in_acc && func == nmcm_pkg::FUNC_QUERY) begin
			query_q <= '{red: color_red, green: color_green, blue: color_blue};
			rnd_q   <= random_value;
			min_d_q <= '1;
			min_i_q <= '0;
			count_q <= '0;
			seen_q  <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
			empty_q <= (entry_count_q == '0);
		end
		if (vld_s2) begin
			case (state_q)
				nmcm_pkg::ST_MIN: begin
					if (dist_s2 < min_d_q) begin
						min_d_q <= dist_s2;
						min_i_q <= idx_s2;
					end
				end
				nmcm_pkg::ST_COUNT: begin
					if (is_good) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				nmcm_pkg::ST_PICK: begin
					if (is_good && !found_q) begin
						if (seen_q == rank_q) begin
							pick_q  <= idx_s2;
							found_q <= 1'b1;
						end else begin
							seen_q <= seen_q + CNT_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == nmcm_pkg::ST_LIMIT) begin
			limit_q <= nmcm_pkg::LIMIT_W'(min_d_q) * nmcm_pkg::LIMIT_W'(tolerance_q);
		end
		if (state_q == nmcm_pkg::ST_RANK) begin
			rank_q <= rank_prod[PROD_W-1:nmcm_pkg::RND_W];
			pick_q <= min_i_q;
		end
		if (out_load) begin
			match_index_q   <= nmcm_pkg::MATCH_W'(pick_q);
			good_count_q    <= nmcm_pkg::GOOD_W'(count_q);
			palette_empty_q <= empty_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_index   = match_index_q;
	assign good_count    = good_count_q;
	assign palette_empty = palette_empty_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= DEPTH_C)
		else $error("entry count beyond palette depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (CNT_W'(idx_s2) < entry_count_q))
		else $error("palette read beyond valid entries");

	a_pick_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nmcm_pkg::ST_PICK) |-> (count_q > CNT_W'(1) && rank_q < count_q))
		else $error("ranking pass without a valid rank");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nmcm_pkg::ST_DONE && out_valid_q && !out_ready)
		|=> (state_q == nmcm_pkg::ST_DONE))
		else $error("result overwritten before it was taken");

	a_pass_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nmcm_pkg::ST_IDLE) |-> (!rd_vld_s1 && !vld_s2))
		else $error("read pipeline busy while idle");
`endif

endmodule
